[sv/rtt_pkg.sv]
package rtt_pkg;

  localparam int unsigned KEEP_COUNT_DEF  = 3;
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_INSERT,
    ST_REPORT
  } back_state_e;

endpackage

[sv/rectangle_top_three_tracker_top.sv]
// Keeps the KEEP_COUNT largest rectangles, ranked by perimeter and then by
// area, with the earlier item winning a full tie.
// The input channel takes one item per handshake: req_type 0 inserts the
// rectangle given by two opposite corners, req_type 1 asks for a report.
// A report returns KEEP_COUNT items on the output channel, smallest first,
// with last_of_run set on the final one. With fewer than KEEP_COUNT inserts
// it returns one item with status and last_of_run set and all else zero.
// A front stage normalizes the corners and forms the side lengths, then a
// two-entry queue feeds the back end, which computes perimeter and area in
// its CALC state and does the compare-insert in the next, its INSERT state.
// An insert passes through the CALC and INSERT states, and the back end
// already pops the next queued item while it is in INSERT.
// A report's items leave the output register one after another, each
// loaded when the register is empty or the receiver takes the one before.
// When the receiver stalls the back end holds, the queue fills and then
// in_ready_o drops. Reset empties the list and clears the insert count.
module rectangle_top_three_tracker_top
  import rtt_pkg::*;
#(
  parameter int unsigned KEEP_COUNT  = KEEP_COUNT_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [COORD_WIDTH-1:0] corner_ax_i,
  input  logic signed [COORD_WIDTH-1:0] corner_ay_i,
  input  logic signed [COORD_WIDTH-1:0] corner_bx_i,
  input  logic signed [COORD_WIDTH-1:0] corner_by_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] x_low_o,
  output logic signed [COORD_WIDTH-1:0] y_low_o,
  output logic signed [COORD_WIDTH-1:0] x_high_o,
  output logic signed [COORD_WIDTH-1:0] y_high_o,
  output logic [COORD_WIDTH+1:0]        rect_perimeter_o,
  output logic [2*COORD_WIDTH-1:0]      rect_area_o,
  output logic                          last_of_run_o,
  output logic                          status_o
);

  localparam int unsigned IW = 6 * COORD_WIDTH + 1;

  logic          push, push_ready, pop_valid, pop;
  logic [IW-1:0] push_item, pop_item;

  rtt_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .corner_ax_i (corner_ax_i),
    .corner_ay_i (corner_ay_i),
    .corner_bx_i (corner_bx_i),
    .corner_by_i (corner_by_i),
    .push_o      (push),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  rtt_queue #(
    .WIDTH(IW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  rtt_back #(
    .KEEP_COUNT (KEEP_COUNT),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_o           (pop),
    .pop_item_i      (pop_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .x_low_o         (x_low_o),
    .y_low_o         (y_low_o),
    .x_high_o        (x_high_o),
    .y_high_o        (y_high_o),
    .rect_perimeter_o(rect_perimeter_o),
    .rect_area_o     (rect_area_o),
    .last_of_run_o   (last_of_run_o),
    .status_o        (status_o)
  );

endmodule

[sv/rtt_front.sv]
module rtt_front
  import rtt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [COORD_WIDTH-1:0] corner_ax_i,
  input  logic signed [COORD_WIDTH-1:0] corner_ay_i,
  input  logic signed [COORD_WIDTH-1:0] corner_bx_i,
  input  logic signed [COORD_WIDTH-1:0] corner_by_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output logic [6*COORD_WIDTH:0]        push_item_o
);

  logic                   valid_q;
  logic [6*COORD_WIDTH:0] item_q;
  logic [6*COORD_WIDTH:0] item_d;
  logic                   accept;
  logic [COORD_WIDTH-1:0] xl, xh, yl, yh, w, h;

  // Corners are normalized and the side lengths formed before queuing.
  always_comb begin
    if (corner_ax_i < corner_bx_i) begin
      xl = corner_ax_i;
      xh = corner_bx_i;
    end else begin
      xl = corner_bx_i;
      xh = corner_ax_i;
    end
    if (corner_ay_i < corner_by_i) begin
      yl = corner_ay_i;
      yh = corner_by_i;
    end else begin
      yl = corner_by_i;
      yh = corner_ay_i;
    end
    w = xh - xl;
    h = yh - yl;
    item_d = {req_type_i, xl, yl, xh, yh, w, h};
  end

  assign in_ready_o  = !valid_q || push_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = valid_q;
  assign push_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

[sv/rtt_queue.sv]
module rtt_queue
  import rtt_pkg::*;
#(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

[sv/rtt_back.sv]
module rtt_back
  import rtt_pkg::*;
#(
  parameter int unsigned KEEP_COUNT  = KEEP_COUNT_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  logic [6*COORD_WIDTH:0]        pop_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] x_low_o,
  output logic signed [COORD_WIDTH-1:0] y_low_o,
  output logic signed [COORD_WIDTH-1:0] x_high_o,
  output logic signed [COORD_WIDTH-1:0] y_high_o,
  output logic [COORD_WIDTH+1:0]        rect_perimeter_o,
  output logic [2*COORD_WIDTH-1:0]      rect_area_o,
  output logic                          last_of_run_o,
  output logic                          status_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned NW  = $clog2(KEEP_COUNT + 1);
  localparam int unsigned RW  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

  back_state_e state_q, state_d;

  logic          head_report;
  logic [CW-1:0] head_xl, head_yl, head_xh, head_yh, head_w, head_h;

  logic [CW-1:0]   wxl_q, wyl_q, wxh_q, wyh_q, ww_q, wh_q;
  logic [CW+1:0]   per_q;
  logic [2*CW-1:0] area_q;

  logic [CW-1:0]   kxl_q [KEEP_COUNT];
  logic [CW-1:0]   kyl_q [KEEP_COUNT];
  logic [CW-1:0]   kxh_q [KEEP_COUNT];
  logic [CW-1:0]   kyh_q [KEEP_COUNT];
  logic [CW+1:0]   kper_q [KEEP_COUNT];
  logic [2*CW-1:0] karea_q [KEEP_COUNT];

  logic [NW-1:0] cnt_q;
  logic [RW-1:0] run_q;
  logic [RW-1:0] slot;

  logic out_valid_q;
  logic pop, do_calc, do_insert, load_out, short_list, run_done;

  logic [NW-1:0] pos;
  logic          found;

  assign {head_report, head_xl, head_yl, head_xh, head_yh, head_w, head_h} = pop_item_i;

  assign short_list = (cnt_q != NW'(KEEP_COUNT));
  assign run_done   = short_list || (run_q == RW'(KEEP_COUNT - 1));
  assign slot       = RW'(KEEP_COUNT - 1) - run_q;

  always_comb begin
    pop       = 1'b0;
    do_calc   = 1'b0;
    do_insert = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop = pop_valid_i;
      end
      ST_CALC: begin
        do_calc = 1'b1;
      end
      ST_INSERT: begin
        do_insert = 1'b1;
        pop       = pop_valid_i;
      end
      ST_REPORT: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_INSERT: begin
        if (pop) begin
          state_d = (head_report == REQ_REPORT) ? ST_REPORT : ST_CALC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        state_d = ST_INSERT;
      end
      ST_REPORT: begin
        if (load_out && run_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The new rectangle goes to the first slot it beats strictly.
  always_comb begin
    pos   = cnt_q;
    found = 1'b0;
    for (int k = 0; k < KEEP_COUNT; k++) begin
      if (!found && (NW'(k) < cnt_q) &&
          ((per_q > kper_q[k]) || ((per_q == kper_q[k]) && (area_q > karea_q[k])))) begin
        pos   = NW'(k);
        found = 1'b1;
      end
    end
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_insert && short_list) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (pop) begin
        run_q <= '0;
      end else if (load_out) begin
        run_q <= run_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      wxl_q <= head_xl;
      wyl_q <= head_yl;
      wxh_q <= head_xh;
      wyh_q <= head_yh;
      ww_q  <= head_w;
      wh_q  <= head_h;
    end
    if (do_calc) begin
      per_q  <= {({1'b0, ww_q} + {1'b0, wh_q}), 1'b0};
      area_q <= ww_q * wh_q;
    end
    if (do_insert) begin
      for (int k = 0; k < KEEP_COUNT; k++) begin
        if (NW'(k) == pos) begin
          kxl_q[k]   <= wxl_q;
          kyl_q[k]   <= wyl_q;
          kxh_q[k]   <= wxh_q;
          kyh_q[k]   <= wyh_q;
          kper_q[k]  <= per_q;
          karea_q[k] <= area_q;
        end
      end
      for (int k = 1; k < KEEP_COUNT; k++) begin
        if (NW'(k) > pos) begin
          kxl_q[k]   <= kxl_q[k-1];
          kyl_q[k]   <= kyl_q[k-1];
          kxh_q[k]   <= kxh_q[k-1];
          kyh_q[k]   <= kyh_q[k-1];
          kper_q[k]  <= kper_q[k-1];
          karea_q[k] <= karea_q[k-1];
        end
      end
    end
    if (load_out) begin
      if (short_list) begin
        x_low_o          <= '0;
        y_low_o          <= '0;
        x_high_o         <= '0;
        y_high_o         <= '0;
        rect_perimeter_o <= '0;
        rect_area_o      <= '0;
        last_of_run_o    <= 1'b1;
        status_o         <= STATUS_SHORT;
      end else begin
        x_low_o          <= kxl_q[slot];
        y_low_o          <= kyl_q[slot];
        x_high_o         <= kxh_q[slot];
        y_high_o         <= kyh_q[slot];
        rect_perimeter_o <= kper_q[slot];
        rect_area_o      <= karea_q[slot];
        last_of_run_o    <= run_done;
        status_o         <= STATUS_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rtt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int KC = KEEP_COUNT_DEF;

  typedef struct packed {
    logic signed [CW-1:0] x_low;
    logic signed [CW-1:0] y_low;
    logic signed [CW-1:0] x_high;
    logic signed [CW-1:0] y_high;
    logic [CW+1:0]        perimeter;
    logic [2*CW-1:0]      area;
  } rect_t;

  typedef struct packed {
    rect_t rect;
    logic  last;
    logic  status;
  } report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i = REQ_INSERT;
  logic signed [CW-1:0] corner_ax_i = '0;
  logic signed [CW-1:0] corner_ay_i = '0;
  logic signed [CW-1:0] corner_bx_i = '0;
  logic signed [CW-1:0] corner_by_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [CW-1:0] x_low_o;
  logic signed [CW-1:0] y_low_o;
  logic signed [CW-1:0] x_high_o;
  logic signed [CW-1:0] y_high_o;
  logic [CW+1:0]        rect_perimeter_o;
  logic [2*CW-1:0]      rect_area_o;
  logic                 last_of_run_o;
  logic                 status_o;

  rect_t   ranked [KC];
  int      rank_fill = 0;
  report_t expected_reports [$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;

  rectangle_top_three_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .corner_ax_i     (corner_ax_i),
    .corner_ay_i     (corner_ay_i),
    .corner_bx_i     (corner_bx_i),
    .corner_by_i     (corner_by_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .x_low_o         (x_low_o),
    .y_low_o         (y_low_o),
    .x_high_o        (x_high_o),
    .y_high_o        (y_high_o),
    .rect_perimeter_o(rect_perimeter_o),
    .rect_area_o     (rect_area_o),
    .last_of_run_o   (last_of_run_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Mirrors the ranking on every accepted item and queues the results it implies.
  task automatic track_rectangle(input logic req, input logic signed [CW-1:0] ax,
                                 input logic signed [CW-1:0] ay,
                                 input logic signed [CW-1:0] bx,
                                 input logic signed [CW-1:0] by);
    rect_t   fresh;
    report_t entry;
    int      w;
    int      h;
    int      pos;
    bit      found;
    if (req == REQ_INSERT) begin
      fresh.x_low  = (ax < bx) ? ax : bx;
      fresh.x_high = (ax < bx) ? bx : ax;
      fresh.y_low  = (ay < by) ? ay : by;
      fresh.y_high = (ay < by) ? by : ay;
      w = int'(fresh.x_high) - int'(fresh.x_low);
      h = int'(fresh.y_high) - int'(fresh.y_low);
      fresh.perimeter = (CW + 2)'(2 * (w + h));
      fresh.area      = (2 * CW)'(longint'(w) * longint'(h));
      pos   = rank_fill;
      found = 1'b0;
      for (int k = 0; k < rank_fill; k++) begin
        if (!found && (fresh.perimeter > ranked[k].perimeter ||
            (fresh.perimeter == ranked[k].perimeter && fresh.area > ranked[k].area))) begin
          pos   = k;
          found = 1'b1;
        end
      end
      if (pos < KC) begin
        for (int k = KC - 1; k > pos; k--) ranked[k] = ranked[k-1];
        ranked[pos] = fresh;
      end
      if (rank_fill < KC) rank_fill++;
    end else if (rank_fill < KC) begin
      entry        = '0;
      entry.last   = 1'b1;
      entry.status = STATUS_SHORT;
      expected_reports.push_back(entry);
    end else begin
      for (int r = 0; r < KC; r++) begin
        entry.rect   = ranked[KC-1-r];
        entry.last   = (r == KC - 1);
        entry.status = STATUS_OK;
        expected_reports.push_back(entry);
      end
    end
  endtask

  task automatic send_item(input logic req, input logic signed [CW-1:0] ax,
                           input logic signed [CW-1:0] ay,
                           input logic signed [CW-1:0] bx,
                           input logic signed [CW-1:0] by);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    corner_ax_i <= ax;
    corner_ay_i <= ay;
    corner_bx_i <= bx;
    corner_by_i <= by;
    do @(posedge clk_i); while (!in_ready_o);
    track_rectangle(req, ax, ay, bx, by);
  endtask

  task automatic send_random_item();
    logic signed [CW-1:0] c [4];
    int                   mode;
    mode = $urandom_range(2);
    for (int k = 0; k < 4; k++) begin
      case (mode)
        0: c[k] = CW'($urandom);
        1: c[k] = CW'($urandom_range(12) - 6);
        default: c[k] = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      endcase
    end
    send_item(($urandom_range(4) == 0) ? REQ_REPORT : REQ_INSERT, c[0], c[1], c[2], c[3]);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [2*CW-1:0] want,
                             input logic [2*CW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    report_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got perimeter %h", $time,
                 rect_perimeter_o);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("x_low", CW'(want.rect.x_low), CW'(x_low_o));
        check_field("y_low", CW'(want.rect.y_low), CW'(y_low_o));
        check_field("x_high", CW'(want.rect.x_high), CW'(x_high_o));
        check_field("y_high", CW'(want.rect.y_high), CW'(y_high_o));
        check_field("rect_perimeter", want.rect.perimeter, rect_perimeter_o);
        check_field("rect_area", want.rect.area, rect_area_o);
        check_field("last_of_run", want.last, last_of_run_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = 150;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 19);
    end
  end

  task automatic test_short_report();
    send_item(REQ_REPORT, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    send_item(REQ_INSERT, 1, 2, 4, 6);
    send_item(REQ_REPORT, 0, 0, 0, 0);
    send_item(REQ_INSERT, -3, 7, 2, -1);
    send_item(REQ_REPORT, -1, -1, -1, -1);
    send_item(REQ_INSERT, 0, 0, 1, 1);
    send_item(REQ_REPORT, 0, 0, 0, 0);
  endtask

  task automatic test_extremes();
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    // The largest rectangle twice, corners swapped: a full tie keeps the earlier one first.
    send_item(REQ_INSERT, lo, lo, hi, hi);
    send_item(REQ_INSERT, hi, hi, lo, lo);
    send_item(REQ_INSERT, 5, 5, 5, 5);
    send_item(REQ_REPORT, hi, lo, hi, lo);
    // The first two have equal perimeters, where the larger area must win.
    send_item(REQ_INSERT, 0, 0, 10, 0);
    send_item(REQ_INSERT, 0, 0, 5, 5);
    send_item(REQ_INSERT, lo, 0, hi, 0);
    send_item(REQ_REPORT, 0, 0, 0, 0);
    // Neither of these beats any kept entry strictly, so both are dropped.
    send_item(REQ_INSERT, lo, 0, hi, 0);
    send_item(REQ_INSERT, -1, -1, 0, 0);
    send_item(REQ_REPORT, lo, hi, lo, hi);
  endtask

  task automatic test_random_quiet();
    quiet = 1'b1;
    repeat (40) send_random_item();
    quiet = 1'b0;
  endtask

  task automatic test_random_idle();
    repeat (60) send_random_item();
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    send_item(REQ_REPORT, 0, 0, 0, 0);
    repeat (12) send_random_item();
  endtask

  task automatic test_sender_pause();
    wait_for_results();
    repeat (30) send_random_item();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_report();
    test_extremes();
    test_random_quiet();
    test_random_idle();
    test_backpressure();
    test_sender_pause();
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
